// ===== src/ole_pkg.sv =====
// Shared types and constants for the ordered list engine.
`timescale 1ns / 1ps
package ole_pkg;

  localparam int OLE_CAPACITY   = 16;
  localparam int OLE_VALUE_BITS = 32;
  localparam int OLE_POS_BITS   = 5;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } ole_status_t;

  typedef enum logic [2:0] {
    RQ_INS_FRONT = 3'd0,
    RQ_INS_POS   = 3'd1,
    RQ_INS_END   = 3'd2,
    RQ_DEL_FRONT = 3'd3,
    RQ_DEL_END   = 3'd4,
    RQ_DEL_POS   = 3'd5,
    RQ_UPDATE    = 3'd6,
    RQ_NONE      = 3'd7
  } ole_req_t;

  typedef enum logic [1:0] {
    K_INS = 2'd0,
    K_DEL = 2'd1,
    K_UPD = 2'd2,
    K_NOP = 2'd3
  } ole_kind_t;

  typedef enum logic [1:0] {
    W_FRONT = 2'd0,
    W_POS   = 2'd1,
    W_END   = 2'd2
  } ole_where_t;

  typedef struct packed {
    ole_kind_t               kind;
    ole_where_t              where;
    logic [OLE_POS_BITS-1:0] pos;
  } ole_ctl_t;

endpackage

// ===== src/ole_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ole_front.sv =====
// Front end: decodes requests and normalizes values into queue commands.
`timescale 1ns / 1ps
module ole_front import ole_pkg::*; #(
  parameter int VALUE_BITS = OLE_VALUE_BITS
) (
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [2:0]                   in_req_type,
  input  logic signed [31:0]           in_value,
  input  logic signed [31:0]           in_new_value,
  input  logic [OLE_POS_BITS-1:0]      in_position,
  output logic                         q_push,
  input  logic                         q_full,
  output ole_ctl_t                     q_ctl,
  output logic [VALUE_BITS-1:0]        q_v,
  output logic [VALUE_BITS-1:0]        q_nv
);

  ole_req_t req;

  assign req     = ole_req_t'(in_req_type);
  assign q_push  = in_push && !q_full;
  assign in_full = q_full;
  assign q_v     = VALUE_BITS'(in_value);
  assign q_nv    = VALUE_BITS'(in_new_value);

  always_comb begin
    q_ctl.pos = in_position;
    case (req)
      RQ_INS_FRONT: begin q_ctl.kind = K_INS; q_ctl.where = W_FRONT; end
      RQ_INS_POS:   begin q_ctl.kind = K_INS; q_ctl.where = W_POS;   end
      RQ_INS_END:   begin q_ctl.kind = K_INS; q_ctl.where = W_END;   end
      RQ_DEL_FRONT: begin q_ctl.kind = K_DEL; q_ctl.where = W_FRONT; end
      RQ_DEL_END:   begin q_ctl.kind = K_DEL; q_ctl.where = W_END;   end
      RQ_DEL_POS:   begin q_ctl.kind = K_DEL; q_ctl.where = W_POS;   end
      RQ_UPDATE:    begin q_ctl.kind = K_UPD; q_ctl.where = W_FRONT; end
      default:      begin q_ctl.kind = K_NOP; q_ctl.where = W_FRONT; end
    endcase
  end

endmodule

// ===== src/ole_cmdq.sv =====
// Two-entry command queue between the front end and the list sequencer.
`timescale 1ns / 1ps
module ole_cmdq #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wptr_r, wptr_nxt;
  logic             rptr_r, rptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop  ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= wdata;
    end
  end

endmodule

// ===== src/ole_back.sv =====
// Back end: sequencer that walks and edits the linked list in RAM.
`timescale 1ns / 1ps
module ole_back import ole_pkg::*; #(
  parameter int CAPACITY   = OLE_CAPACITY,
  parameter int VALUE_BITS = OLE_VALUE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cmd_valid,
  input  ole_ctl_t                          cmd_ctl,
  input  logic [VALUE_BITS-1:0]             cmd_v,
  input  logic [VALUE_BITS-1:0]             cmd_nv,
  output logic                              cmd_pop,
  output logic                              res_valid,
  input  logic                              res_pop,
  output ole_status_t                       res_status,
  output logic [$clog2(CAPACITY+1)-1:0]     res_count,
  output logic signed [VALUE_BITS-1:0]      res_removed
);

  localparam int SW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int PW = ((LW > OLE_POS_BITS) ? LW : OLE_POS_BITS) + 1;
  localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_ALLOC  = 11'b000_0000_0010,
    S_INS_W  = 11'b000_0000_0100,
    S_WISSUE = 11'b000_0000_1000,
    S_WALK   = 11'b000_0001_0000,
    S_INS_A  = 11'b000_0010_0000,
    S_INS_B  = 11'b000_0100_0000,
    S_DEL_A  = 11'b000_1000_0000,
    S_DEL_B  = 11'b001_0000_0000,
    S_UPD_I  = 11'b010_0000_0000,
    S_UPD    = 11'b100_0000_0000
  } state_t;

  state_t                state_r, state_nxt;
  logic [SW-1:0]         head_r, head_nxt;
  logic [LW-1:0]         len_r, len_nxt;
  logic [LW-1:0]         fresh_r, fresh_nxt;
  logic [LW-1:0]         fcnt_r, fcnt_nxt;
  logic [SW-1:0]         fhead_r, fhead_nxt;
  logic [SW-1:0]         cur_r, cur_nxt;
  logic [SW-1:0]         prev_r, prev_nxt;
  logic [SW-1:0]         pprev_r, pprev_nxt;
  logic [SW-1:0]         slot_r, slot_nxt;
  logic [LW-1:0]         n_r, n_nxt;
  logic [PW-1:0]         p_r, p_nxt;
  logic                  del_r, del_nxt;
  logic [VALUE_BITS-1:0] v_r, v_nxt;
  logic [VALUE_BITS-1:0] nv_r, nv_nxt;
  logic                  ov_r, ov_nxt;
  ole_status_t           ost_r, ost_nxt;
  logic [LW-1:0]         ocnt_r, ocnt_nxt;
  logic [VALUE_BITS-1:0] orem_r, orem_nxt;

  logic                  lk_we, en_we;
  logic [SW-1:0]         lk_waddr, lk_wdata, lk_raddr, lk_rdata;
  logic [SW-1:0]         en_waddr, en_raddr;
  logic [VALUE_BITS-1:0] en_wdata, en_rdata;
  logic [PW-1:0]         p_w, len_e;

  ole_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_link (
    .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
    .raddr(lk_raddr), .rdata(lk_rdata)
  );

  ole_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_entry (
    .clk(clk), .we(en_we), .waddr(en_waddr), .wdata(en_wdata),
    .raddr(en_raddr), .rdata(en_rdata)
  );

  assign res_valid   = ov_r;
  assign res_status  = ost_r;
  assign res_count   = ocnt_r;
  assign res_removed = orem_r;

  assign len_e = PW'(len_r);

  // Resolve the 1-based target position from the request form
  always_comb begin
    case (cmd_ctl.where)
      W_FRONT: p_w = PW'(1);
      W_END:   p_w = (cmd_ctl.kind == K_INS) ? len_e + PW'(1) : len_e;
      W_POS:   p_w = PW'(cmd_ctl.pos);
      default: p_w = PW'(cmd_ctl.pos);
    endcase
  end

  // Read ports follow the link read data during walks, so each step reads the next entry
  always_comb begin
    if (state_r == S_WALK || state_r == S_UPD) begin
      lk_raddr = lk_rdata;
    end else if (state_r == S_IDLE) begin
      lk_raddr = fhead_r;
    end else begin
      lk_raddr = cur_r;
    end
    if (state_r == S_UPD) begin
      en_raddr = lk_rdata;
    end else if (state_r == S_DEL_A) begin
      en_raddr = prev_r;
    end else begin
      en_raddr = cur_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    len_nxt   = len_r;
    fresh_nxt = fresh_r;
    fcnt_nxt  = fcnt_r;
    fhead_nxt = fhead_r;
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    pprev_nxt = pprev_r;
    slot_nxt  = slot_r;
    n_nxt     = n_r;
    p_nxt     = p_r;
    del_nxt   = del_r;
    v_nxt     = v_r;
    nv_nxt    = nv_r;
    ov_nxt    = (ov_r && !res_pop);
    ost_nxt   = ost_r;
    ocnt_nxt  = ocnt_r;
    orem_nxt  = orem_r;
    cmd_pop   = 1'b0;
    lk_we     = 1'b0;
    lk_waddr  = slot_r;
    lk_wdata  = cur_r;
    en_we     = 1'b0;
    en_waddr  = slot_r;
    en_wdata  = v_r;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid && !ov_r) begin
          cmd_pop  = 1'b1;
          ost_nxt  = ST_OK;
          ocnt_nxt = len_r;
          orem_nxt = '0;
          v_nxt    = cmd_v;
          nv_nxt   = cmd_nv;
          p_nxt    = p_w;
          cur_nxt  = head_r;
          case (cmd_ctl.kind)
            K_INS: begin
              if (len_r == CAP_L) begin
                ost_nxt = ST_FULL;
                ov_nxt  = 1'b1;
              end else if (p_w == '0 || p_w > len_e + PW'(1)) begin
                ost_nxt = ST_BADPOS;
                ov_nxt  = 1'b1;
              end else if (fcnt_r != '0) begin
                slot_nxt  = fhead_r;
                state_nxt = S_ALLOC;
              end else begin
                slot_nxt  = fresh_r[SW-1:0];
                fresh_nxt = fresh_r + LW'(1);
                state_nxt = S_INS_W;
              end
            end
            K_DEL: begin
              if (len_r == '0) begin
                ost_nxt = ST_EMPTY;
                ov_nxt  = 1'b1;
              end else if (p_w == '0 || p_w > len_e) begin
                ost_nxt = ST_BADPOS;
                ov_nxt  = 1'b1;
              end else begin
                n_nxt     = LW'(p_w);
                del_nxt   = 1'b1;
                state_nxt = S_WISSUE;
              end
            end
            K_UPD: begin
              if (len_r == '0) begin
                ost_nxt = ST_EMPTY;
                ov_nxt  = 1'b1;
              end else begin
                n_nxt     = len_r;
                state_nxt = S_UPD_I;
              end
            end
            default: begin
              ov_nxt = 1'b1;
            end
          endcase
        end
      end
      S_ALLOC: begin
        // pop the recycled slot off the free chain
        fhead_nxt = lk_rdata;
        fcnt_nxt  = fcnt_r - LW'(1);
        state_nxt = S_INS_W;
      end
      S_INS_W: begin
        en_we = 1'b1;
        if (p_r == PW'(1)) begin
          lk_we     = 1'b1;
          lk_wdata  = head_r;
          head_nxt  = slot_r;
          len_nxt   = len_r + LW'(1);
          ocnt_nxt  = len_r + LW'(1);
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cur_nxt   = head_r;
          n_nxt     = LW'(p_r - PW'(1));
          del_nxt   = 1'b0;
          state_nxt = S_WISSUE;
        end
      end
      S_WISSUE: begin
        state_nxt = S_WALK;
      end
      S_WALK: begin
        pprev_nxt = prev_r;
        prev_nxt  = cur_r;
        cur_nxt   = lk_rdata;
        n_nxt     = n_r - LW'(1);
        if (n_r == LW'(1)) begin
          state_nxt = del_r ? S_DEL_A : S_INS_A;
        end
      end
      S_INS_A: begin
        lk_we     = 1'b1;
        state_nxt = S_INS_B;
      end
      S_INS_B: begin
        lk_we     = 1'b1;
        lk_waddr  = prev_r;
        lk_wdata  = slot_r;
        len_nxt   = len_r + LW'(1);
        ocnt_nxt  = len_r + LW'(1);
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_DEL_A: begin
        // prev holds the victim, cur its successor
        if (p_r == PW'(1)) begin
          head_nxt = cur_r;
        end else begin
          lk_we    = 1'b1;
          lk_waddr = pprev_r;
        end
        state_nxt = S_DEL_B;
      end
      S_DEL_B: begin
        lk_we     = 1'b1;
        lk_waddr  = prev_r;
        lk_wdata  = fhead_r;
        fhead_nxt = prev_r;
        fcnt_nxt  = fcnt_r + LW'(1);
        len_nxt   = len_r - LW'(1);
        ocnt_nxt  = len_r - LW'(1);
        orem_nxt  = en_rdata;
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_UPD_I: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (en_rdata == v_r) begin
          en_we     = 1'b1;
          en_waddr  = cur_r;
          en_wdata  = nv_r;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else if (n_r == LW'(1)) begin
          ost_nxt   = ST_NOTFOUND;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cur_nxt = lk_rdata;
          n_nxt   = n_r - LW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      len_r   <= '0;
      fresh_r <= '0;
      fcnt_r  <= '0;
      fhead_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      len_r   <= len_nxt;
      fresh_r <= fresh_nxt;
      fcnt_r  <= fcnt_nxt;
      fhead_r <= fhead_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    prev_r  <= prev_nxt;
    pprev_r <= pprev_nxt;
    slot_r  <= slot_nxt;
    n_r     <= n_nxt;
    p_r     <= p_nxt;
    del_r   <= del_nxt;
    v_r     <= v_nxt;
    nv_r    <= nv_nxt;
    ost_r   <= ost_nxt;
    ocnt_r  <= ocnt_nxt;
    orem_r  <= orem_nxt;
  end

endmodule

// ===== src/ordered_list_engine_unit.sv =====
// Top level of the ordered list engine: front end, command queue, sequencer.
`timescale 1ns / 1ps
// A bounded singly linked list of signed values held in two RAMs (values and
// next-links). Requests enter through a two-entry command queue, so new
// requests are taken while the sequencer works and while a result waits.
// Each request yields one result: status, entry count and removed value.
// The time a request takes is set by the sequencer's list walk, one linked
// entry per cycle over the single link RAM read port; rejected requests,
// undefined codes and inserts at the front skip the walk. No clearing pass
// runs after reset.
module ordered_list_engine_unit import ole_pkg::*; #(
  parameter int CAPACITY   = OLE_CAPACITY,
  parameter int VALUE_BITS = OLE_VALUE_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  logic [2:0]              in_req_type,
  input  logic signed [31:0]      in_value,
  input  logic signed [31:0]      in_new_value,
  input  logic [OLE_POS_BITS-1:0] in_position,
  output logic                    empty,
  input  logic                    pop,
  output logic [2:0]              out_status,
  output logic [4:0]              out_entry_count,
  output logic signed [31:0]      out_removed_value
);

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int QW = $bits(ole_ctl_t) + 2 * VALUE_BITS;

  logic                         q_push, q_full, q_empty, q_pop;
  ole_ctl_t                     f_ctl, b_ctl;
  logic [VALUE_BITS-1:0]        f_v, f_nv, b_v, b_nv;
  logic [QW-1:0]                q_rdata;
  logic                         res_valid;
  ole_status_t                  res_status;
  logic [LW-1:0]                res_count;
  logic signed [VALUE_BITS-1:0] res_removed;

  ole_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .in_push(push), .in_full(full), .in_req_type(in_req_type),
    .in_value(in_value), .in_new_value(in_new_value), .in_position(in_position),
    .q_push(q_push), .q_full(q_full), .q_ctl(f_ctl), .q_v(f_v), .q_nv(f_nv)
  );

  ole_cmdq #(.WIDTH(QW)) u_cmdq (
    .clk(clk), .rst_n(rst_n), .push(q_push), .wdata({f_ctl, f_v, f_nv}),
    .full(q_full), .pop(q_pop), .rdata(q_rdata), .empty(q_empty)
  );

  assign {b_ctl, b_v, b_nv} = q_rdata;

  ole_back #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(!q_empty), .cmd_ctl(b_ctl),
    .cmd_v(b_v), .cmd_nv(b_nv), .cmd_pop(q_pop), .res_valid(res_valid),
    .res_pop(pop), .res_status(res_status), .res_count(res_count),
    .res_removed(res_removed)
  );

  assign empty             = !res_valid;
  assign out_status        = res_status;
  assign out_entry_count   = 5'(res_count);
  assign out_removed_value = 32'(res_removed);

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the ordered list engine, with a list predictor.
`timescale 1ns / 1ps
module testbench;
  import ole_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1000;
  localparam int CALM_ITEMS = 150;

  typedef logic signed [31:0] val_t;

  typedef struct {
    ole_status_t status;
    logic [4:0]  count;
    val_t        removed;
  } list_result_t;

  logic       clk;
  logic       rst_n;
  logic       push;
  logic       full;
  logic [2:0] in_req_type;
  val_t       in_value;
  val_t       in_new_value;
  logic [4:0] in_position;
  logic       empty;
  logic       pop;
  logic [2:0] out_status;
  logic [4:0] out_entry_count;
  val_t       out_removed_value;

  val_t         shadow_list[$];
  list_result_t pending_results[$];
  int           errors = 0;
  int           cycles = 0;
  int           stall_left = 0;
  bit           idle_ok = 1'b1;

  ordered_list_engine_unit dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_req_type(in_req_type), .in_value(in_value), .in_new_value(in_new_value),
    .in_position(in_position), .empty(empty), .pop(pop), .out_status(out_status),
    .out_entry_count(out_entry_count), .out_removed_value(out_removed_value)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[ordered_list_engine_unit] ERROR");
      $finish;
    end
  end

  // Apply one request to the shadow list and return what the block must report.
  function automatic list_result_t apply_request(ole_req_t rq, val_t v, val_t nv,
                                                 logic [4:0] p);
    list_result_t r;
    int at;
    int n;
    r.status  = ST_OK;
    r.removed = '0;
    n = shadow_list.size();
    case (rq)
      RQ_INS_FRONT, RQ_INS_POS, RQ_INS_END: begin
        at = (rq == RQ_INS_FRONT) ? 1 : (rq == RQ_INS_END) ? n + 1 : int'(p);
        if (n >= OLE_CAPACITY) r.status = ST_FULL;
        else if (at < 1 || at > n + 1) r.status = ST_BADPOS;
        else shadow_list.insert(at - 1, v);
      end
      RQ_DEL_FRONT, RQ_DEL_END, RQ_DEL_POS: begin
        at = (rq == RQ_DEL_FRONT) ? 1 : (rq == RQ_DEL_END) ? n : int'(p);
        if (n == 0) r.status = ST_EMPTY;
        else if (at < 1 || at > n) r.status = ST_BADPOS;
        else begin
          r.removed = shadow_list[at - 1];
          shadow_list.delete(at - 1);
        end
      end
      RQ_UPDATE: begin
        if (n == 0) r.status = ST_EMPTY;
        else begin
          r.status = ST_NOTFOUND;
          foreach (shadow_list[i]) begin
            if (shadow_list[i] == v) begin
              shadow_list[i] = nv;
              r.status = ST_OK;
              break;
            end
          end
        end
      end
      default: ;
    endcase
    r.count = 5'(shadow_list.size());
    return r;
  endfunction

  task automatic send_req(ole_req_t rq, val_t v, val_t nv, logic [4:0] p);
    int gap;
    if (idle_ok && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push         <= 1'b1;
    in_req_type  <= rq;
    in_value     <= v;
    in_new_value <= nv;
    in_position  <= p;
    do @(posedge clk); while (full);
    pending_results.push_back(apply_request(rq, v, nv, p));
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result side: check each transfer, then pick pop for the next cycle.
  always @(posedge clk) begin
    list_result_t e;
    if (rst_n && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result status=%0d count=%0d", out_status, out_entry_count);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status);
          errors++;
        end
        if (out_entry_count !== e.count) begin
          $error("entry_count: expected %0d, got %0d", e.count, out_entry_count);
          errors++;
        end
        if (out_removed_value !== e.removed) begin
          $error("removed_value: expected %0d, got %0d", e.removed, out_removed_value);
          errors++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if (idle_ok && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic test_directed();
    send_req(RQ_DEL_FRONT, 0, 0, 1);
    send_req(RQ_DEL_END, 0, 0, 1);
    send_req(RQ_DEL_POS, 0, 0, 1);
    send_req(RQ_UPDATE, 0, 1, 1);
    send_req(RQ_INS_POS, 5, 0, 0);
    send_req(RQ_INS_POS, 5, 0, 2);
    send_req(RQ_INS_POS, 32'sh8000_0000, 0, 1);
    send_req(RQ_INS_END, 32'sh7fff_ffff, 0, 31);
    send_req(RQ_INS_FRONT, -1, 0, 0);
    send_req(RQ_INS_POS, 42, 0, 4);
    send_req(RQ_INS_POS, 7, 0, 2);
    send_req(RQ_UPDATE, 32'sh7fff_ffff, 32'sh8000_0000, 0);
    send_req(RQ_UPDATE, 12345, 1, 0);
    send_req(RQ_DEL_POS, 0, 0, 0);
    send_req(RQ_DEL_POS, 0, 0, 31);
    send_req(RQ_DEL_POS, 0, 0, 5);
    send_req(RQ_DEL_POS, 0, 0, 2);
    send_req(RQ_NONE, -1, -1, 31);
    send_req(RQ_DEL_END, 0, 0, 0);
    send_req(RQ_DEL_FRONT, 0, 0, 0);
  endtask

  // Fill to capacity, bounce off the full check, then drain at random positions.
  task automatic test_full_list();
    while (shadow_list.size() < OLE_CAPACITY)
      send_req(RQ_INS_END, val_t'($urandom), 0, 0);
    send_req(RQ_INS_FRONT, 1, 0, 0);
    send_req(RQ_INS_POS, 1, 0, 31);
    send_req(RQ_INS_POS, 1, 0, 17);
    send_req(RQ_DEL_POS, 0, 0, 16);
    send_req(RQ_INS_POS, 99, 0, 16);
    send_req(RQ_DEL_POS, 0, 0, 17);
    while (shadow_list.size() > 0)
      send_req(RQ_DEL_POS, 0, 0, 5'($urandom_range(1, shadow_list.size())));
  endtask

  task automatic test_pause();
    wait_drained();
  endtask

  task automatic test_random();
    int n;
    int pick;
    int bias;
    val_t v;
    ole_req_t rq;
    logic [4:0] p;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS - CALM_ITEMS) idle_ok = 1'b0;
      n = shadow_list.size();
      bias = ((k / 100) % 2 == 0) ? 60 : 35;
      pick = $urandom_range(0, 99);
      v = val_t'($urandom);
      if (n > 0 && $urandom_range(0, 1) == 0)
        v = shadow_list[$urandom_range(0, n - 1)];
      if ($urandom_range(0, 9) == 0) begin
        rq = ole_req_t'($urandom_range(0, 7));
        p  = 5'($urandom);
      end else if (pick < bias) begin
        rq = ole_req_t'($urandom_range(RQ_INS_FRONT, RQ_INS_END));
        p  = 5'($urandom_range(1, n + 1));
      end else if (pick < 85) begin
        rq = ole_req_t'($urandom_range(RQ_DEL_FRONT, RQ_DEL_POS));
        p  = 5'($urandom_range(1, (n > 0) ? n : 1));
      end else begin
        rq = RQ_UPDATE;
        p  = 5'($urandom);
      end
      send_req(rq, v, val_t'($urandom), p);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    push         = 1'b0;
    pop          = 1'b0;
    in_req_type  = '0;
    in_value     = '0;
    in_new_value = '0;
    in_position  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_list();
    test_pause();
    test_random();
    wait_drained();
    repeat (40) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[ordered_list_engine_unit] OK");
    end else begin
      $display("[ordered_list_engine_unit] ERROR");
    end
    $finish;
  end

endmodule
